>>> rtl/core/assert_macros.svh
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/rdct_pkg.sv
package rdct_pkg;

    localparam int unsigned CYC_W   = 64;
    localparam int unsigned CPC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CTL_W   = 3;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PROD_W  = CPC_W + BYTE_W;

    localparam logic [CTL_W-1:0] CTL_MASK = 3'h7;
    localparam int unsigned CTL_RUN_BIT    = 0;
    localparam int unsigned CTL_PRESET_BIT = 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] OFF_CTRL   = 2'd0;
    localparam logic [1:0] OFF_RELOAD = 2'd1;

    localparam logic [CYC_W-1:0] WAKE_NONE = {CYC_W{1'b1}};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_MUL  = 6'b001000,
        S_DONE = 6'b010000,
        S_WAIT = 6'b100000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> rtl/core/rdct_div.sv
`include "assert_macros.svh"

module rdct_div
    import rdct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CYC_W-1:0] i_dividend,
    input  logic [CPC_W-1:0] i_divisor,
    output logic [CYC_W-1:0] o_quotient,
    output logic [CPC_W-1:0] o_remainder,
    output t_div_status      o_status
);

    logic [CYC_W-1:0] r_quo;
    logic [CPC_W-1:0] r_rem;
    logic [CPC_W-1:0] r_div;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CPC_W:0]   shifted;
    logic [CPC_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring form
    assign shifted = {r_rem, r_quo[CYC_W-1]};
    assign trial   = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[CYC_W-2:0], fits};
            r_rem <= fits ? trial[CPC_W-1:0] : shifted[CPC_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_status    = '{busy: r_busy, done: r_done};

    `ASSERT_IMPL(a_no_restart, i_start, !r_busy, "divider started while busy")
    `ASSERT_IMPL(a_div_nonzero, r_busy, r_div != '0, "divider running on zero divisor")
    `ASSERT_IMPL(a_done_idle, r_done, !r_busy, "divider done while still busy")

endmodule

>>> rtl/core/reload_down_counter_timer.sv
// one 8-bit reload down-counter timer channel with catch-up
// input stream: one transaction per item; tuser[1:0] is the kind
// (tick, bus read, bus write), tdata carries offset, write data and cycle
// output stream: exactly one result transaction per accepted item
// config channel: cpu cycles per count, zero stops the clock; write it only
// while no item is in work
// a read, a write or a tick that is not yet due has its result in the
// output register 2 cycles after the accept, and the next item can be taken
// one cycle later, so 3 cycles per item
// a due tick runs the shared 64-step serial divider once (counts due), 67
// cycles to the result and 68 per item, or twice after an underflow (reload
// modulo), 132 cycles to the result and 133 per item
// the input is not ready while an item is in work; it is ready again as
// soon as the result is in the output register, even if that result is
// still stalled, and a stalled result holds the sequencer before its
// next result
// reset clears control, reload, counter, next due cycle and cycles per
// count, and empties the output register
`include "assert_macros.svh"

module reload_down_counter_timer
    import rdct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_wdata,     // cpu cycles per count
    // item input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,  // reg_offset[1:0], write_data[17:2], cycle_now[81:18]
    input  logic [1:0]  i_s_axis_tuser,  // opcode[1:0]
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata   // read_data[15:0], underflow_irq[16], running[17],
                                         // next_wake[81:18]
);

    // architectural state
    logic [CPC_W-1:0]  r_cpc;
    logic [CTL_W-1:0]  r_ctl;
    logic [BYTE_W-1:0] r_reload;
    logic [BYTE_W-1:0] r_count;
    logic [CYC_W-1:0]  r_next;

    // per-item working registers
    t_state             r_state;
    logic [CYC_W-1:0]   r_now;
    logic [DATA_W-1:0]  r_rd;
    logic               r_irq;
    logic [PROD_W-1:0]  r_prod;

    // output register
    logic               r_out_valid;
    logic [87:0]        r_out_data;

    // divider hookup
    logic               div_start;
    logic [CYC_W-1:0]   div_dividend;
    logic [CPC_W-1:0]   div_divisor;
    logic [CYC_W-1:0]   div_quo;
    logic [CPC_W-1:0]   div_rem;
    t_div_status        div_st;

    // input fields
    logic [1:0]        in_op;
    logic [1:0]        in_off;
    logic [DATA_W-1:0] in_wdata;
    logic [CYC_W-1:0]  in_now;
    logic              in_fire;
    logic              tick_due;
    logic              q_below;
    logic [CYC_W-1:0]  wake;
    logic              out_free;

    assign in_op    = i_s_axis_tuser;
    assign in_off   = i_s_axis_tdata[1:0];
    assign in_wdata = i_s_axis_tdata[17:2];
    assign in_now   = i_s_axis_tdata[81:18];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // a tick only counts when running, clocked and at or past the due cycle
    assign tick_due = r_ctl[CTL_RUN_BIT] && (r_cpc != '0) && (in_now >= r_next);

    // quotient below the counter: no underflow this tick
    assign q_below = (div_quo[CYC_W-1:BYTE_W] == '0) && (div_quo[BYTE_W-1:0] < r_count);

    // divider start: counts due on a due tick, then reload modulo after underflow
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_now - r_next;
        div_divisor  = r_cpc;
        case (r_state)
            S_IDLE: begin
                div_start    = in_fire && (in_op == OP_TICK) && tick_due;
                div_dividend = in_now - r_next;
            end
            S_DIV1: begin
                div_start    = div_st.done && !q_below;
                div_dividend = div_quo - {{(CYC_W-BYTE_W){1'b0}}, r_count};
                div_divisor  = {{(CPC_W-BYTE_W-1){1'b0}}, {1'b0, r_reload} + 9'd1};
            end
            default: begin
            end
        endcase
    end

    rdct_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_status    (div_st)
    );

    assign wake = (!r_ctl[CTL_RUN_BIT] || (r_cpc == '0)) ? WAKE_NONE
                : r_next + {{(CYC_W-PROD_W){1'b0}}, r_prod};

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpc <= '0;
        end else if (i_cfg_valid) begin
            r_cpc <= i_cfg_wdata;
        end
    end

    // sequencer and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctl    <= '0;
            r_reload <= '0;
            r_count  <= '0;
            r_next   <= '0;
            r_irq    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_now   <= in_now;
                        r_irq   <= 1'b0;
                        r_state <= div_start ? S_DIV1 : S_MUL;
                        if (in_op == OP_READ && !in_off[1]) begin
                            r_rd <= {r_reload, {(BYTE_W-CTL_W){1'b0}}, r_ctl};
                        end else if (in_op == OP_READ) begin
                            r_rd <= {{(DATA_W-BYTE_W){1'b0}}, r_count};
                        end else begin
                            r_rd <= '0;
                        end
                        if (in_op == OP_WRITE) begin
                            if (in_off == OFF_CTRL) begin
                                r_ctl    <= in_wdata[CTL_W-1:0] & CTL_MASK;
                                r_reload <= in_wdata[DATA_W-1:BYTE_W];
                                // preset takes the reload value from before this write
                                if (in_wdata[CTL_PRESET_BIT]) begin
                                    r_count <= r_reload;
                                end
                            end else if (in_off == OFF_RELOAD) begin
                                r_reload <= in_wdata[BYTE_W-1:0];
                            end
                        end
                    end
                end
                S_DIV1: begin
                    if (div_st.done) begin
                        // next + q*cpc + cpc equals now - remainder + cpc
                        r_next <= r_now - {{(CYC_W-CPC_W){1'b0}}, div_rem}
                                + {{(CYC_W-CPC_W){1'b0}}, r_cpc};
                        if (q_below) begin
                            r_count <= r_count - div_quo[BYTE_W-1:0] - 8'd1;
                            r_state <= S_MUL;
                        end else begin
                            r_irq   <= 1'b1;
                            r_state <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_st.done) begin
                        r_count <= r_reload - div_rem[BYTE_W-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_count * r_cpc);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= out_free ? S_IDLE : S_WAIT;
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register, loaded once the result is complete and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE || r_state == S_WAIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE || r_state == S_WAIT) && out_free) begin
            r_out_data <= {6'd0, wake, r_ctl[CTL_RUN_BIT], r_irq, r_rd};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `ASSERT_IMPL(a_done_in_div, div_st.done, r_state == S_DIV1 || r_state == S_DIV2,
                 "divider result outside a divide state")
    `ASSERT_IMPL(a_div2_irq, r_state == S_DIV2, r_irq, "modulo pass without underflow")
    `ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
                 "input ready straight after accept")

endmodule
